// File: sv/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg
// Types and constants shared by the MIDI message parser files.
// ----------------------------------------------------------------------------
package mmp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DATA_W = 7;

    localparam logic [3:0] NIBBLE_NOTE_ON = 4'h9;
    localparam logic [3:0] NIBBLE_CTRL    = 4'hB;

    localparam logic KIND_NOTE_ON = 1'b0;
    localparam logic KIND_CTRL    = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT_STATUS   = 3'd0,
        PH_WAIT_NOTE     = 3'd1,
        PH_WAIT_CTRL_NUM = 3'd2,
        PH_WAIT_VELOCITY = 3'd3,
        PH_WAIT_CTRL_VAL = 3'd4
    } t_phase;

endpackage

// File: sv/midi_message_parser.sv
// ----------------------------------------------------------------------------
// midi_message_parser
// Parses received MIDI bytes into note-on and controller-change messages.
// ----------------------------------------------------------------------------
// Input channel: one received MIDI byte per word (i_in_valid / o_in_ready).
// Output channel: one completed message per word (o_out_valid / i_out_ready):
// kind (0 note on, 1 controller change), first and second data byte.
// Status bytes 0x9n and 0xBn start a message, any other status byte drops
// back to waiting; data bytes outside a message are dropped. No running
// status; the channel nibble is not reported.
// Path: a byte is taken into the input register and parsed there; its
// message (if any) is written into the output register when the parse
// step is taken, which can wait while an output word is stalled.
// Throughput: one byte per cycle, set by the single parse stage between the
// input and output registers, except while a completing byte waits (see Stall).
// Reset: both registers empty, parser waiting for a status byte.
// Stall: while a message waits in the output register, bytes that produce
// no message still flow through; a byte that completes a message holds in
// the input register until the output word is taken.
// ----------------------------------------------------------------------------
module midi_message_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [mmp_pkg::BYTE_W-1:0]       i_midi_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_msg_kind,
    output logic [mmp_pkg::DATA_W-1:0]       o_first_data,
    output logic [mmp_pkg::DATA_W-1:0]       o_second_data
);

    logic                         r_in_vld;
    logic [mmp_pkg::BYTE_W-1:0]   r_in_byte;
    mmp_pkg::t_phase              r_phase, n_phase;
    logic [mmp_pkg::DATA_W-1:0]   r_held, n_held;
    logic                         r_out_vld;
    logic                         r_out_kind;
    logic [mmp_pkg::DATA_W-1:0]   r_out_first, r_out_second;

    logic                         is_status;
    logic [mmp_pkg::DATA_W-1:0]   data;
    logic                         emit;
    logic                         emit_kind;
    logic                         out_free;
    logic                         proc;

    assign is_status = r_in_byte[mmp_pkg::BYTE_W-1];
    assign data      = r_in_byte[mmp_pkg::DATA_W-1:0];
    assign out_free  = !r_out_vld || i_out_ready;
    assign proc      = r_in_vld && (!emit || out_free);
    assign o_in_ready = !r_in_vld || proc;

    always_comb begin
        n_phase   = r_phase;
        n_held    = r_held;
        emit      = 1'b0;
        emit_kind = mmp_pkg::KIND_NOTE_ON;
        if (is_status) begin
            priority if (r_in_byte[7:4] == mmp_pkg::NIBBLE_NOTE_ON) begin
                n_phase = mmp_pkg::PH_WAIT_NOTE;
            end else if (r_in_byte[7:4] == mmp_pkg::NIBBLE_CTRL) begin
                n_phase = mmp_pkg::PH_WAIT_CTRL_NUM;
            end else begin
                n_phase = mmp_pkg::PH_WAIT_STATUS;
            end
        end else begin
            unique case (r_phase)
                mmp_pkg::PH_WAIT_NOTE: begin
                    n_held  = data;
                    n_phase = mmp_pkg::PH_WAIT_VELOCITY;
                end
                mmp_pkg::PH_WAIT_CTRL_NUM: begin
                    n_held  = data;
                    n_phase = mmp_pkg::PH_WAIT_CTRL_VAL;
                end
                mmp_pkg::PH_WAIT_VELOCITY: begin
                    emit      = 1'b1;
                    emit_kind = mmp_pkg::KIND_NOTE_ON;
                    n_phase   = mmp_pkg::PH_WAIT_STATUS;
                end
                mmp_pkg::PH_WAIT_CTRL_VAL: begin
                    emit      = 1'b1;
                    emit_kind = mmp_pkg::KIND_CTRL;
                    n_phase   = mmp_pkg::PH_WAIT_STATUS;
                end
                default: begin
                    n_phase = mmp_pkg::PH_WAIT_STATUS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_phase   <= mmp_pkg::PH_WAIT_STATUS;
            r_held    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (proc) begin
                r_phase <= n_phase;
                r_held  <= n_held;
            end
            if (proc && emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_midi_byte;
        end
        if (proc && emit) begin
            r_out_kind   <= emit_kind;
            r_out_first  <= r_held;
            r_out_second <= data;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_msg_kind    = r_out_kind;
    assign o_first_data  = r_out_first;
    assign o_second_data = r_out_second;

endmodule

// File: sv/mmp_checker.sv
// ----------------------------------------------------------------------------
// mmp_checker
// Port-level checks for the MIDI message parser, bound to the top level.
// ----------------------------------------------------------------------------
module mmp_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_ready,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic                             o_msg_kind,
    input  logic [mmp_pkg::DATA_W-1:0]       o_first_data,
    input  logic [mmp_pkg::DATA_W-1:0]       o_second_data
);

    // output word stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_msg_kind) && $stable(o_first_data) && $stable(o_second_data))
        else $error("output word changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // with an empty output register nothing can block the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    // a fresh message is caused by an accepted input byte
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("output word without cause");

endmodule

bind midi_message_parser mmp_checker u_mmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_msg_kind    (o_msg_kind),
    .o_first_data  (o_first_data),
    .o_second_data (o_second_data)
);
